/* rtl/core/tlbp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tlbp_pkg;

  localparam int unsigned PixW      = 8;
  localparam int unsigned ColW      = 9;
  localparam int unsigned RowW      = 12;
  localparam int unsigned SumW      = PixW + 1;
  localparam int unsigned X1W       = 8;
  localparam int unsigned Y1W       = 11;
  localparam int unsigned X2W       = 7;
  localparam int unsigned MaxWidth  = 320;
  localparam int unsigned L1Depth   = MaxWidth / 2;
  localparam int unsigned L2Depth   = MaxWidth / 4;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 12;
  localparam int unsigned OutDataW  = 32;

  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 1'b1;

  localparam logic LevelOne = 1'b0;
  localparam logic LevelTwo = 1'b1;

  localparam logic [ColW-1:0] WidthReset  = ColW'(320);
  localparam logic [RowW-1:0] HeightReset = RowW'(240);

  // One level-0 column pair that reaches the line store.
  typedef struct packed {
    logic [X1W-1:0]  x1;
    logic [Y1W-1:0]  y1;
    logic            odd_row;
    logic [SumW-1:0] pair;
  } pair_item_t;

  // Rounded mean of two pair sums.
  function automatic logic [PixW-1:0] box_mean(input logic [SumW-1:0] a,
                                               input logic [SumW-1:0] b);
    logic [SumW+1:0] s;
    s = {2'b00, a} + {2'b00, b} + (SumW+2)'(2);
    return s[PixW+1:2];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/tlbp_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module tlbp_ram #(
  parameter int unsigned Width = 9,
  parameter int unsigned Depth = 160
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tlbp_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module tlbp_front
  import tlbp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [PixW-1:0]     s_axis_tdata,
  input  wire logic                q_full_i,
  output      logic                push_o,
  output      pair_item_t          push_item_o
);

  logic [ColW-1:0] width_q;
  logic [RowW-1:0] height_q;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [PixW-1:0] held_q;
  logic [ColW-1:0] eff_w;
  logic            in_range;
  logic            take;

  assign s_axis_tready = ~q_full_i;
  assign take          = s_axis_tvalid & ~q_full_i;

  assign eff_w    = (width_q > ColW'(MaxWidth)) ? ColW'(MaxWidth) : width_q;
  assign in_range = (col_q < eff_w) && (row_q < height_q);

  assign push_o           = take & in_range & col_q[0];
  assign push_item_o.x1   = col_q[ColW-1:1];
  assign push_item_o.y1   = row_q[RowW-1:1];
  assign push_item_o.odd_row = row_q[0];
  assign push_item_o.pair = {1'b0, held_q} + {1'b0, s_axis_tdata};

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if ({1'b0, col_q} + (ColW+1)'(1) >= {1'b0, eff_w}) begin
      col_d = '0;
      if ({1'b0, row_q} + (RowW+1)'(1) >= {1'b0, height_q}) begin
        row_d = '0;
      end else begin
        row_d = row_q + RowW'(1);
      end
    end else begin
      col_d = col_q + ColW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      col_q    <= '0;
      row_q    <= '0;
      held_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgFrameWidth:  width_q  <= cfg_data_i[ColW-1:0];
          CfgFrameHeight: height_q <= cfg_data_i[RowW-1:0];
          default: ;
        endcase
      end
      if (take) begin
        col_q <= col_d;
        row_q <= row_d;
        if (in_range && !col_q[0]) begin
          held_q <= s_axis_tdata;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tlbp_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module tlbp_queue
  import tlbp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire pair_item_t push_item_i,
  output      logic       full_o,
  input  wire logic       pop_i,
  output      logic       valid_o,
  output      pair_item_t head_o
);

  pair_item_t         slot_q [QDepth];
  logic [QPtrW-1:0]   wr_q, rd_q;
  logic [QPtrW:0]     cnt_q;
  logic               do_pop;

  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rd_q];
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      case ({push_i, do_pop})
        2'b10:   cnt_q <= cnt_q + (QPtrW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (QPtrW+1)'(1);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tlbp_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module tlbp_back
  import tlbp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_valid_i,
  input  wire pair_item_t          q_item_i,
  output      logic                q_pop_o,
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output      logic [OutDataW-1:0] m_axis_tdata,
  output      logic                m_axis_tuser,
  output      logic                m_axis_tlast
);

  localparam int unsigned L1AW = $clog2(L1Depth);
  localparam int unsigned L2AW = $clog2(L2Depth);

  logic            adv;
  logic [SumW-1:0] l1_rdata, l2_rdata;

  logic            s2_valid_q;
  pair_item_t      s2_q;
  logic [PixW-1:0] v1;
  logic [PixW-1:0] l1_held_q;
  logic [SumW-1:0] pair2;
  logic            l2_we;

  logic            s3_valid_q;
  logic [X1W-1:0]  s3_x1_q;
  logic [Y1W-1:0]  s3_y1_q;
  logic [PixW-1:0] s3_v1_q;
  logic            s3_has_l2_q;
  logic [SumW-1:0] s3_pair2_q;
  logic            phase_q;
  logic [PixW-1:0] v2;

  // The whole back pipeline moves together once the output word set is gone.
  assign adv     = ~s3_valid_q | (m_axis_tready & m_axis_tlast);
  assign q_pop_o = adv & q_valid_i;

  tlbp_ram #(.Width(SumW), .Depth(L1Depth)) u_l1_store (
    .clk_i   (clk_i),
    .we_i    (adv & q_valid_i & ~q_item_i.odd_row),
    .waddr_i (q_item_i.x1[L1AW-1:0]),
    .wdata_i (q_item_i.pair),
    .re_i    (adv),
    .raddr_i (q_item_i.x1[L1AW-1:0]),
    .rdata_o (l1_rdata)
  );

  assign v1    = box_mean(l1_rdata, s2_q.pair);
  assign pair2 = {1'b0, l1_held_q} + {1'b0, v1};
  assign l2_we = adv & s2_valid_q & s2_q.x1[0] & ~s2_q.y1[0];

  tlbp_ram #(.Width(SumW), .Depth(L2Depth)) u_l2_store (
    .clk_i   (clk_i),
    .we_i    (l2_we),
    .waddr_i (s2_q.x1[L2AW:1]),
    .wdata_i (pair2),
    .re_i    (adv),
    .raddr_i (s2_q.x1[L2AW:1]),
    .rdata_o (l2_rdata)
  );

  assign v2 = box_mean(l2_rdata, s3_pair2_q);

  assign m_axis_tvalid = s3_valid_q;
  assign m_axis_tlast  = ~s3_has_l2_q | phase_q;
  assign m_axis_tuser  = phase_q ? LevelTwo : LevelOne;

  always_comb begin
    if (phase_q) begin
      m_axis_tdata = {5'b0, v2, 1'b0, s3_y1_q[Y1W-1:1], 1'b0, s3_x1_q[X1W-1:1]};
    end else begin
      m_axis_tdata = {5'b0, s3_v1_q, s3_y1_q, s3_x1_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q        <= q_item_i;
      s3_x1_q     <= s2_q.x1;
      s3_y1_q     <= s2_q.y1;
      s3_v1_q     <= v1;
      s3_pair2_q  <= pair2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s3_has_l2_q <= 1'b0;
      phase_q     <= 1'b0;
      l1_held_q   <= '0;
    end else begin
      if (adv) begin
        s2_valid_q  <= q_valid_i & q_item_i.odd_row;
        s3_valid_q  <= s2_valid_q;
        s3_has_l2_q <= s2_valid_q & s2_q.x1[0] & s2_q.y1[0];
        phase_q     <= 1'b0;
        if (s2_valid_q && !s2_q.x1[0]) begin
          l1_held_q <= v1;
        end
      end else if (m_axis_tready && s3_valid_q) begin
        phase_q <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/two_level_box_pyramid_top.sv */
// Two-level 2x2 box pyramid. Grey level-0 pixels enter on the s_axis channel
// in raster order, one word per pixel, frames back to back. Each level-1
// pixel is the rounded mean of a 2x2 level-0 block and each level-2 pixel the
// same over level 1; an odd last column or row of a level is dropped.
// Results leave on m_axis: tuser gives the level (0 = level 1, 1 = level 2),
// tdata the column, row and value, and tlast marks the last word caused by
// one input pixel. A pixel that completes a level-2 block yields two words,
// level 1 first.
// Frame width and height are written through the cfg channel, which is always
// ready; the user must write them only while the block is idle, as the block
// itself does not enforce it. Reset sets 320 by 240 and starts a new frame at
// the top left corner. A pixel is taken every cycle while the four-entry pair
// queue has room. The first word of a result is valid once its pair has passed
// the queue and the stage-2 and stage-3 registers; the back end handles one
// queued pair a cycle while the output is not stalled, and a pixel with two
// results holds the output stage until both are taken. When the receiver stalls,
// the back end freezes and the queue fills, after which s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module two_level_box_pyramid_top
  import tlbp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [PixW-1:0]     s_axis_tdata,  // pixel_in
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output      logic [OutDataW-1:0] m_axis_tdata,  // out_x, out_y, pixel_value
  output      logic                m_axis_tuser,  // level
  output      logic                m_axis_tlast
);

  logic       push;
  pair_item_t push_item;
  logic       q_full;
  logic       q_valid;
  pair_item_t q_head;
  logic       q_pop;

  assign cfg_ready_o = 1'b1;

  tlbp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_item_o   (push_item)
  );

  tlbp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  tlbp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_head),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire
